[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-qualified property checks used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LCPS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lcps_pkg.sv]
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types, widths and constants of the line centroid PD steering unit.
// ----------------------------------------------------------------------------
package lcps_pkg;

    localparam int ROW_PIXELS = 320;
    localparam int HALF_ROW   = ROW_PIXELS / 2;
    localparam int COL_W      = $clog2(ROW_PIXELS + 1);
    localparam int SUM_W      = 17;
    localparam int AVG_W      = 9;
    localparam int DRV_W      = 9;
    localparam int Q_W        = 24;
    localparam int ACC_W      = 27;
    localparam int DRV_MAX    = 255;

    localparam int DVD_W      = 35;
    localparam int DVS_W      = (COL_W > 8) ? COL_W : 8;
    localparam int DIV_CNT_W  = $clog2(DVD_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam longint Q_MAX_MAG = (64'sd1 <<< (Q_W - 1)) - 64'sd1;
    localparam longint Q_MIN_MAG = (64'sd1 <<< (Q_W - 1));

    localparam logic signed [DRV_W-1:0] SEARCH_RIGHT  = -9'sd45;
    localparam logic signed [DRV_W-1:0] SEARCH_LEFT   = 9'sd40;
    localparam logic signed [DRV_W-1:0] DRV_BAD_CODE  = {1'b1, {(DRV_W-1){1'b0}}};

    localparam logic [7:0] RST_THRESH    = 8'd100;
    localparam logic [7:0] RST_MAX_SPEED = 8'd90;
    localparam logic [7:0] RST_KP        = 8'd40;
    localparam logic [7:0] RST_MAX_P     = 8'd160;
    localparam logic [7:0] RST_KD        = 8'd0;
    localparam logic [7:0] RST_MAX_D     = 8'd10;
    localparam logic [9:0] RST_RATE      = 10'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESH,
        CFG_MAX_SPEED,
        CFG_KP,
        CFG_MAX_P,
        CFG_KD,
        CFG_MAX_D,
        CFG_RATE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_ROW,
        S_CHK,
        S_DIV_AVG,
        S_MUL1,
        S_MUL2,
        S_DIV_P,
        S_DIV_D,
        S_FIN
    } t_state;

    typedef struct packed {
        logic in_stall;
        logic pix_take;
        logic div_avg;
        logic take_avg;
        logic take_mul1;
        logic take_mul2;
        logic div_p;
        logic take_p;
        logic div_d;
        logic take_d;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic div_done;
        logic out_busy;
    } t_sts;

endpackage

[hw/rtl/lcps_div.sv]
// ----------------------------------------------------------------------------
// lcps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcps_div import lcps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);

    logic [DVD_W-1:0]     r_quo;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_run;
    logic                 r_done;

    logic [DVS_W:0]   w_rsh;
    logic [DVS_W+1:0] w_sub;
    logic             w_ge;
    logic [DVS_W-1:0] n_rem;

    always_comb begin
        w_rsh = {r_rem, r_quo[DVD_W-1]};
        w_sub = {1'b0, w_rsh} - {2'b00, r_dvs};
        w_ge  = !w_sub[DVS_W+1];
        n_rem = w_ge ? w_sub[DVS_W-1:0] : w_rsh[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DVD_W - 1);
        end else begin
            r_done <= r_run && (r_cnt == '0);
            if (r_run) begin
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

[hw/rtl/lcps_dp.sv]
// ----------------------------------------------------------------------------
// lcps_dp
// Datapath: configuration, row accumulators, PD terms and the result register.
// ----------------------------------------------------------------------------
module lcps_dp import lcps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [7:0]              i_pixel,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [DRV_W-1:0] o_right_drive,
    output logic signed [DRV_W-1:0] o_left_drive,
    output logic                    o_line_found,
    output logic signed [AVG_W-1:0] o_average_offset
);

    function automatic logic signed [Q_W-1:0] sat_term(
        input logic [DVD_W-1:0] quo,
        input logic             neg,
        input logic             zero,
        input logic [7:0]       gain
    );
        logic signed [Q_W-1:0] val;
        logic signed [Q_W-1:0] lim;
        lim = {{(Q_W-16){1'b0}}, gain, 8'b0};
        if (zero) begin
            val = '0;
        end else if (!neg) begin
            val = (quo > DVD_W'(Q_MAX_MAG)) ? Q_MAX : quo[Q_W-1:0];
        end else begin
            val = (quo > DVD_W'(Q_MIN_MAG)) ? Q_MIN : -quo[Q_W-1:0];
        end
        if (val > lim) begin
            val = lim;
        end
        return val;
    endfunction

    function automatic logic signed [DRV_W-1:0] to_drive(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-9:0] v;
        t = x[ACC_W-1] ? x + ACC_W'(255) : x;
        v = t[ACC_W-1:8];
        if (v > DRV_MAX) begin
            return DRV_W'(DRV_MAX);
        end else if (v < -DRV_MAX) begin
            return DRV_W'(-DRV_MAX);
        end
        return v[DRV_W-1:0];
    endfunction

    logic [7:0] r_thresh;
    logic [7:0] r_max_speed;
    logic [7:0] r_kp;
    logic [7:0] r_max_p;
    logic [7:0] r_kd;
    logic [7:0] r_max_d;
    logic [9:0] r_rate;

    logic [COL_W-1:0] r_col;
    logic [SUM_W-1:0] r_sum;
    logic [COL_W-1:0] r_cnt;
    logic signed [AVG_W-1:0] r_held;

    logic signed [AVG_W-1:0] r_avg;
    logic [16:0]             r_pmul;
    logic                    r_p_neg;
    logic [18:0]             r_dmul1;
    logic                    r_d_neg;
    logic [26:0]             r_dmul2;
    logic signed [Q_W-1:0]   r_p;
    logic signed [Q_W-1:0]   r_d;

    logic                    r_out_valid;
    logic signed [DRV_W-1:0] r_right;
    logic signed [DRV_W-1:0] r_left;
    logic                    r_found;
    logic signed [AVG_W-1:0] r_avg_out;

    logic             w_in_row;
    logic             w_bright;
    logic [SUM_W-1:0] w_offset;
    logic             w_sum_neg;
    logic [SUM_W-1:0] w_sum_mag;
    logic [AVG_W-1:0] w_avg_mag;
    logic [AVG_W:0]   w_diff;
    logic [AVG_W:0]   w_diff_mag;
    logic             w_div_start;
    logic [DVD_W-1:0] w_dividend;
    logic [DVS_W-1:0] w_divisor;
    logic [DVD_W-1:0] w_quo;
    logic             w_div_done;
    logic [10:0]      w_base11;
    logic signed [ACC_W-1:0] w_base;
    logic signed [ACC_W-1:0] w_pd;
    logic signed [ACC_W-1:0] w_right;
    logic signed [ACC_W-1:0] w_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= RST_THRESH;
            r_max_speed <= RST_MAX_SPEED;
            r_kp        <= RST_KP;
            r_max_p     <= RST_MAX_P;
            r_kd        <= RST_KD;
            r_max_d     <= RST_MAX_D;
            r_rate      <= RST_RATE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_THRESH:    r_thresh    <= i_cfg_data[7:0];
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[7:0];
                CFG_KP:        r_kp        <= i_cfg_data[7:0];
                CFG_MAX_P:     r_max_p     <= i_cfg_data[7:0];
                CFG_KD:        r_kd        <= i_cfg_data[7:0];
                CFG_MAX_D:     r_max_d     <= i_cfg_data[7:0];
                CFG_RATE:      r_rate      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_in_row  = r_col < COL_W'(ROW_PIXELS);
        w_bright  = i_pixel > r_thresh;
        w_offset  = SUM_W'(r_col) - SUM_W'(HALF_ROW);
        w_sum_neg = r_sum[SUM_W-1];
        w_sum_mag = w_sum_neg ? -r_sum : r_sum;
        w_avg_mag = r_avg[AVG_W-1] ? -r_avg : r_avg;
        w_diff    = {r_avg[AVG_W-1], r_avg} - {r_held[AVG_W-1], r_held};
        w_diff_mag = w_diff[AVG_W] ? -w_diff : w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.finish) begin
            r_col <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.pix_take && w_in_row) begin
            r_col <= r_col + 1'b1;
            if (w_bright) begin
                r_sum <= r_sum + w_offset;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        w_div_start = i_cmd.div_avg || i_cmd.div_p || i_cmd.div_d;
        priority if (i_cmd.div_avg) begin
            w_dividend = DVD_W'(w_sum_mag);
            w_divisor  = DVS_W'(r_cnt);
        end else if (i_cmd.div_p) begin
            w_dividend = DVD_W'({r_pmul, 8'b0});
            w_divisor  = DVS_W'(r_max_p);
        end else begin
            w_dividend = {r_dmul2, 8'b0};
            w_divisor  = DVS_W'(r_max_d);
        end
    end

    lcps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_avg) begin
            r_avg <= w_sum_neg ? -w_quo[AVG_W-1:0] : w_quo[AVG_W-1:0];
        end
        if (i_cmd.take_mul1) begin
            r_pmul  <= 17'(w_avg_mag * r_kp);
            r_p_neg <= r_avg[AVG_W-1];
            r_dmul1 <= 19'(w_diff_mag[AVG_W-1:0] * r_rate);
            r_d_neg <= w_diff[AVG_W];
        end
        if (i_cmd.take_mul2) begin
            r_dmul2 <= 27'(r_dmul1 * r_kd);
        end
        if (i_cmd.take_p) begin
            r_p <= sat_term(w_quo, r_p_neg, r_pmul == '0, r_kp);
        end
        if (i_cmd.take_d) begin
            r_d <= sat_term(w_quo, r_d_neg, r_dmul2 == '0, r_kd);
        end
    end

    always_comb begin
        w_base11 = {3'b000, r_max_speed} - {3'b000, r_kp} - {3'b000, r_kd};
        w_base   = {{(ACC_W-19){w_base11[10]}}, w_base11, 8'b0};
        w_pd     = {{(ACC_W-Q_W){r_p[Q_W-1]}}, r_p} + {{(ACC_W-Q_W){r_d[Q_W-1]}}, r_d};
        w_right  = w_base - w_pd;
        w_left   = w_base + w_pd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
            if (r_cnt != '0) begin
                r_held <= r_avg;
            end
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_cnt != '0) begin
                r_right   <= to_drive(w_right);
                r_left    <= to_drive(w_left);
                r_found   <= 1'b1;
                r_avg_out <= r_avg;
            end else begin
                r_right   <= SEARCH_RIGHT;
                r_left    <= SEARCH_LEFT;
                r_found   <= 1'b0;
                r_avg_out <= r_held;
            end
        end
    end

    always_comb begin
        o_sts.count_zero = r_cnt == '0;
        o_sts.div_done   = w_div_done;
        o_sts.out_busy   = r_out_valid;
    end

    assign o_out_valid      = r_out_valid;
    assign o_right_drive    = r_right;
    assign o_left_drive     = r_left;
    assign o_line_found     = r_found;
    assign o_average_offset = r_avg_out;

endmodule

[hw/rtl/lcps_ctrl.sv]
// ----------------------------------------------------------------------------
// lcps_ctrl
// Controller: pixel intake, end-of-row sequencing and result hand-off.
// ----------------------------------------------------------------------------
module lcps_ctrl import lcps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_last_in_row,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ROW;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.in_stall = 1'b1;
        unique case (r_state)
            S_ROW: begin
                o_cmd.in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.pix_take = 1'b1;
                    if (i_last_in_row) begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (i_sts.count_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_avg = 1'b1;
                    n_state = S_DIV_AVG;
                end
            end
            S_DIV_AVG: begin
                if (i_sts.div_done) begin
                    o_cmd.take_avg = 1'b1;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.take_mul1 = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.take_mul2 = 1'b1;
                o_cmd.div_p = 1'b1;
                n_state = S_DIV_P;
            end
            S_DIV_P: begin
                if (i_sts.div_done) begin
                    o_cmd.take_p = 1'b1;
                    o_cmd.div_d = 1'b1;
                    n_state = S_DIV_D;
                end
            end
            S_DIV_D: begin
                if (i_sts.div_done) begin
                    o_cmd.take_d = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_ROW;
                end
            end
        endcase
    end

endmodule

[hw/rtl/line_centroid_pd_steering_unit.sv]
// ----------------------------------------------------------------------------
// line_centroid_pd_steering_unit
// Line follower steering from one camera row: centroid plus PD control.
// ----------------------------------------------------------------------------
// Pixels of a row are taken one per cycle. After the pixel marked last in row
// the unit stalls its input while it forms the result: when a bright pixel
// was seen, three passes of the shared divider for the average, the
// proportional and the derivative term, plus the states S_CHK, S_MUL1, S_MUL2
// and S_FIN; only S_CHK and S_FIN when the row held no bright pixel. The
// result sits in an output register, so the next row streams in while it
// waits to be taken; the finishing step of that row's end-of-row sequence
// waits for the register to free up.
module line_centroid_pd_steering_unit import lcps_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_pixel,
    input  logic                    i_last_in_row,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [DRV_W-1:0] o_right_drive,
    output logic signed [DRV_W-1:0] o_left_drive,
    output logic                    o_line_found,
    output logic signed [AVG_W-1:0] o_average_offset
);

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_cmd.in_stall;

    lcps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_in_row (i_last_in_row),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    lcps_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_pixel          (i_pixel),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_right_drive    (o_right_drive),
        .o_left_drive     (o_left_drive),
        .o_line_found     (o_line_found),
        .o_average_offset (o_average_offset)
    );

endmodule

[hw/rtl/lcps_chk.sv]
// ----------------------------------------------------------------------------
// lcps_chk
// Port-level checks of the steering unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcps_chk import lcps_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [DRV_W-1:0] o_right_drive,
    input logic signed [DRV_W-1:0] o_left_drive,
    input logic                    o_line_found,
    input logic signed [AVG_W-1:0] o_average_offset
);

    logic                       w_out_wait;
    logic [2*DRV_W+AVG_W:0]     w_beat;
    logic                       w_search_ok;
    logic                       w_range_ok;

    assign w_out_wait  = o_out_valid && i_out_stall;
    assign w_beat      = {o_right_drive, o_left_drive, o_line_found, o_average_offset};
    assign w_search_ok = (o_right_drive == SEARCH_RIGHT) && (o_left_drive == SEARCH_LEFT);
    assign w_range_ok  = (o_right_drive != DRV_BAD_CODE) && (o_left_drive != DRV_BAD_CODE);

    `LCPS_ASSERT_NEXT(a_out_hold, w_out_wait, o_out_valid, "result beat dropped while stalled")
    `LCPS_ASSERT_NEXT(a_out_stable, w_out_wait, $stable(w_beat), "stalled result beat changed")
    `LCPS_ASSERT_IMPL(a_search, o_out_valid && !o_line_found, w_search_ok, "search drives wrong")
    `LCPS_ASSERT_IMPL(a_drive_range, o_out_valid, w_range_ok, "drive outside saturation range")

endmodule

bind line_centroid_pd_steering_unit lcps_chk u_lcps_chk (.*);

[bench/line_centroid_pd_steering_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_centroid_pd_steering_unit_test
// Streams camera rows into the steering unit and checks every wheel-drive beat
// against a built-in centroid/PD predictor, across several register settings
// and sender/receiver idle patterns.
// ----------------------------------------------------------------------------
module line_centroid_pd_steering_unit_test;
    import lcps_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 40;
    localparam int SETTLE       = 150;
    localparam int QUIET_LIMIT  = 5000;

    typedef struct {
        logic [7:0] pixel;
        logic       last;
    } t_pixel_beat;

    typedef struct {
        logic signed [DRV_W-1:0] right_drv;
        logic signed [DRV_W-1:0] left_drv;
        logic                    found;
        logic signed [AVG_W-1:0] avg;
    } t_drive_result;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic [7:0]              i_pixel;
    logic                    i_last_in_row;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [DRV_W-1:0] o_right_drive;
    logic signed [DRV_W-1:0] o_left_drive;
    logic                    o_line_found;
    logic signed [AVG_W-1:0] o_average_offset;

    t_pixel_beat   pixel_feed[$];
    t_drive_result drive_expect[$];

    logic running;
    logic in_took;
    logic cfg_took;
    int   sender_idle_pct;
    int   stall_pct;
    int   pixels_sent;
    int   pixels_taken;
    int   rows_sent;
    int   drives_checked;
    int   search_rows;
    int   mismatches;
    int   quiet_cycles;

    // predictor copy of the registers and row state
    int cfg_thresh;
    int cfg_speed;
    int cfg_kp;
    int cfg_max_p;
    int cfg_kd;
    int cfg_max_d;
    int cfg_rate;
    int row_column;
    int row_sum;
    int row_bright;
    int held_avg;

    line_centroid_pd_steering_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_pixel          (i_pixel),
        .i_last_in_row    (i_last_in_row),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_right_drive    (o_right_drive),
        .o_left_drive     (o_left_drive),
        .o_line_found     (o_line_found),
        .o_average_offset (o_average_offset)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint q_quotient(longint num, int den);
        longint q;
        if (den == 0) begin
            if (num > 0) return Q_MAX_MAG;
            if (num < 0) return -Q_MIN_MAG;
            return 0;
        end
        q = num / den;
        if (q > Q_MAX_MAG) q = Q_MAX_MAG;
        if (q < -Q_MIN_MAG) q = -Q_MIN_MAG;
        return q;
    endfunction

    function automatic logic signed [DRV_W-1:0] wheel_drive(longint q);
        longint v;
        v = q / 256;
        if (v > DRV_MAX) v = DRV_MAX;
        if (v < -DRV_MAX) v = -DRV_MAX;
        return v[DRV_W-1:0];
    endfunction

    task automatic apply_setting(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_THRESH:    cfg_thresh = value[7:0];
            CFG_MAX_SPEED: cfg_speed  = value[7:0];
            CFG_KP:        cfg_kp     = value[7:0];
            CFG_MAX_P:     cfg_max_p  = value[7:0];
            CFG_KD:        cfg_kd     = value[7:0];
            CFG_MAX_D:     cfg_max_d  = value[7:0];
            CFG_RATE:      cfg_rate   = value;
            default: ;
        endcase
    endtask

    task automatic track_pixel(logic [7:0] pix, logic last);
        t_drive_result r;
        int            avg;
        longint        p;
        longint        d;
        longint        delta;
        longint        base;
        if (row_column < ROW_PIXELS) begin
            if (int'(pix) > cfg_thresh) begin
                row_sum += row_column - HALF_ROW;
                row_bright++;
            end
            row_column++;
        end
        if (last) begin
            if (row_bright == 0) begin
                r.right_drv = SEARCH_RIGHT;
                r.left_drv  = SEARCH_LEFT;
                r.found     = 1'b0;
            end else begin
                avg   = row_sum / row_bright;
                p     = q_quotient(longint'(avg) * cfg_kp * 256, cfg_max_p);
                delta = (longint'(avg) - held_avg) * cfg_rate;
                d     = q_quotient(delta * cfg_kd * 256, cfg_max_d);
                base  = (longint'(cfg_speed) - cfg_kp - cfg_kd) * 256;
                if (p > longint'(cfg_kp) * 256) p = longint'(cfg_kp) * 256;
                if (d > longint'(cfg_kd) * 256) d = longint'(cfg_kd) * 256;
                r.right_drv = wheel_drive(base - (p + d));
                r.left_drv  = wheel_drive(base + (p + d));
                r.found     = 1'b1;
                held_avg    = avg;
            end
            r.avg = held_avg[AVG_W-1:0];
            drive_expect.push_back(r);
            row_column = 0;
            row_sum    = 0;
            row_bright = 0;
        end
    endtask

    task automatic report_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic check_drive();
        t_drive_result r;
        if (drive_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected drive beat right %0d left %0d", $time,
                         o_right_drive, o_left_drive);
        end else begin
            r = drive_expect.pop_front();
            drives_checked++;
            if (!r.found) search_rows++;
            if (o_right_drive !== r.right_drv)
                report_mismatch("right_drive", r.right_drv, o_right_drive);
            if (o_left_drive !== r.left_drv)
                report_mismatch("left_drive", r.left_drv, o_left_drive);
            if (o_line_found !== r.found)
                report_mismatch("line_found", r.found, o_line_found);
            if (o_average_offset !== r.avg)
                report_mismatch("average_offset", r.avg, o_average_offset);
        end
    endtask

    // driver: change inputs on the falling edge
    always @(negedge i_clk) begin : drive_pixels
        t_pixel_beat beat;
        if (running) begin
            if (!i_in_valid || in_took) begin
                if (pixel_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    beat = pixel_feed.pop_front();
                    i_in_valid    <= 1'b1;
                    i_pixel       <= beat.pixel;
                    i_last_in_row <= beat.last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor: sample on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_took      <= 1'b0;
            cfg_took     <= 1'b0;
            cfg_thresh   = RST_THRESH;
            cfg_speed    = RST_MAX_SPEED;
            cfg_kp       = RST_KP;
            cfg_max_p    = RST_MAX_P;
            cfg_kd       = RST_KD;
            cfg_max_d    = RST_MAX_D;
            cfg_rate     = RST_RATE;
            row_column   = 0;
            row_sum      = 0;
            row_bright   = 0;
            held_avg     = 0;
            quiet_cycles = 0;
        end else begin
            in_took  <= i_in_valid && !o_in_stall;
            cfg_took <= i_cfg_valid && o_cfg_ready;
            quiet_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                apply_setting(t_cfg_idx'(i_cfg_index), i_cfg_data);
                quiet_cycles = 0;
            end
            if (i_in_valid && !o_in_stall) begin
                track_pixel(i_pixel, i_last_in_row);
                pixels_taken++;
                quiet_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                check_drive();
                quiet_cycles = 0;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic push_pixel(logic [7:0] pix, logic last);
        t_pixel_beat beat;
        beat.pixel = pix;
        beat.last  = last;
        pixel_feed.push_back(beat);
        pixels_sent++;
        if (last) rows_sent++;
    endtask

    task automatic push_row(int len, bit shaped);
        int center;
        int width;
        logic [7:0] pix;
        center = $urandom_range(len - 1, 0);
        width  = $urandom_range(8, 0);
        for (int c = 0; c < len; c++) begin
            if (!shaped)
                pix = 8'($urandom_range(255, 0));
            else if (c >= center - width && c <= center + width)
                pix = 8'($urandom_range(255, 160));
            else
                pix = 8'($urandom_range(90, 0));
            push_pixel(pix, c == len - 1);
        end
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_took);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixels_taken != pixels_sent || drive_expect.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin : run_rows
        logic [CFG_DATA_W-1:0] knob [0:CFG_RATE];
        t_cfg_idx k;
        int fed;
        int len;
        int sel;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_THRESH;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_pixel         = '0;
        i_last_in_row   = 1'b0;
        i_out_stall     = 1'b0;
        running         = 1'b0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        pixels_sent     = 0;
        pixels_taken    = 0;
        rows_sent       = 0;
        drives_checked  = 0;
        search_rows     = 0;
        mismatches      = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;

        // single bright pixel at column zero, single dark pixel
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd0, 1'b1);
        // threshold boundary: equal is dark, one above is bright
        push_pixel(8'd100, 1'b0);
        push_pixel(8'd101, 1'b0);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd255, 1'b1);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b0);
        push_pixel(8'd255, 1'b1);
        for (int c = 0; c < 6; c++) push_pixel(8'd0, 1'b0);
        push_pixel(8'd200, 1'b1);
        push_pixel(8'd0, 1'b0);
        push_pixel(8'd0, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: knob = '{10'd100, 10'd90, 10'd40, 10'd160, 10'd20, 10'd10, 10'd10};
                    2: knob = '{10'd255, 10'd255, 10'd255, 10'd255, 10'd255, 10'd255,
                                10'd1023};
                    3: knob = '{10'd0, 10'd0, 10'd255, 10'd0, 10'd255, 10'd0, 10'd1023};
                    4: knob = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
                    5: knob = '{10'd128, 10'd255, 10'd255, 10'd1, 10'd255, 10'd1, 10'd1023};
                    default: begin
                        knob[CFG_THRESH]    = CFG_DATA_W'($urandom_range(255, 0));
                        knob[CFG_MAX_SPEED] = CFG_DATA_W'($urandom_range(255, 0));
                        knob[CFG_KP]        = CFG_DATA_W'($urandom_range(255, 0));
                        knob[CFG_MAX_P]     = CFG_DATA_W'($urandom_range(255, 0));
                        knob[CFG_KD]        = CFG_DATA_W'($urandom_range(255, 0));
                        knob[CFG_MAX_D]     = CFG_DATA_W'($urandom_range(255, 0));
                        knob[CFG_RATE]      = CFG_DATA_W'($urandom_range(1023, 0));
                    end
                endcase
                k = k.first();
                do begin
                    cfg_write(k, knob[k]);
                    k = k.next();
                end while (k != k.first());
                i_cfg_valid <= 1'b0;
            end
            @(posedge i_clk);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  stall_pct = 0;  end
                1: begin sender_idle_pct = 66; stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  stall_pct = 66; end
                default: begin sender_idle_pct = 32; stall_pct = 32; end
            endcase
            fed = 0;
            while (fed < PHASE_PIXELS) begin
                sel = $urandom_range(99, 0);
                if (fed == 0 && phase == 1)      len = ROW_PIXELS + 10;
                else if (fed == 0 && phase == 3) len = ROW_PIXELS;
                else if (fed == 0 && phase == 5) len = ROW_PIXELS + 2;
                else if (sel < 88) len = $urandom_range(16, 1);
                else if (sel < 96) len = $urandom_range(64, 17);
                else if (sel < 98) len = $urandom_range(ROW_PIXELS, 290);
                else               len = $urandom_range(ROW_PIXELS + 16, ROW_PIXELS + 1);
                push_row(len, $urandom_range(99, 0) < 75);
                fed += len;
            end
            wait_drained();
        end

        $display("Fed %0d rows (%0d pixels) over %0d register settings and idle patterns;",
                 rows_sent, pixels_sent, PHASES);
        $display("checked %0d drive beats, %0d of them search drives.",
                 drives_checked, search_rows);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
